>>> design/sfl_pkg.sv
package sfl_pkg;

	// Fixed field and register widths.
	localparam int SAMPLE_W = 16;
	localparam int FRAC_W   = 16;
	localparam int BASE_W   = 26;
	localparam int STEP_W   = 16;
	localparam int MAXSW_W  = 25;
	localparam int GAIN_W   = 16;
	localparam int POS_W    = 26;
	// base_delay plus sweep position, and its integer part.
	localparam int SUM_W    = 27;
	localparam int INT_W    = SUM_W - FRAC_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 26;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_STEP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SWEEP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIX_GAIN      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STEREO_ENABLE = 3'd4;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_TAP,
		ST_RD1,
		ST_RD2,
		ST_MUL,
		ST_INT,
		ST_GAIN,
		ST_DONE
	} sfl_state_t;

endpackage

>>> design/sfl_ram.sv
module sfl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/stereo_flanger.sv
// Stereo flanger with a triangle sweep and a linearly interpolated delay line.
// A sequencer walks each pair through delay reduction, two taps on the single read
// port, and two multiply stages; a new input transfer is accepted only once the result
// has been handed to the output register, so a stalled output also holds the input.
// Reset: arst_n clears all control state, then a clearing pass writes zero into every
// address of both delay stores while s_axis_tready stays low.
module stereo_flanger
	import sfl_pkg::*;
#(
	parameter int DELAY_DEPTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [15:0] left_sample, [31:16] right_sample
	input  logic [31:0]           s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [15:0] left_out, [31:16] right_out
	output logic [31:0]           m_axis_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// Address width of the delay stores.
	localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
	// The integer part of the delay is reduced modulo the depth by restoring
	// subtraction of shifted multiples of the depth; KS steps cover its range.
	localparam int KS = (AW > INT_W) ? 1 : INT_W + 1 - AW;
	localparam int RW = AW + KS;
	localparam logic [RW-1:0]   DEP_R = RW'(DELAY_DEPTH);
	localparam logic [AW+1:0]   DEP_T = (AW + 2)'(DELAY_DEPTH);
	localparam logic [AW-1:0]   LAST  = AW'(DELAY_DEPTH - 1);

	sfl_state_t state_q, state_d;

	// Configuration registers.
	logic [BASE_W-1:0]  base_delay_q;
	logic [STEP_W-1:0]  sweep_step_q;
	logic [MAXSW_W-1:0] max_sweep_q;
	logic [GAIN_W-1:0]  mix_gain_q;
	logic               stereo_q;

	// Block state outside the stores.
	logic [AW-1:0]      write_index_q;
	logic [POS_W-1:0]   sweep_pos_q;
	logic               sweep_falling_q;
	logic [AW-1:0]      clr_addr_q;

	// Per-item working registers.
	logic signed [SAMPLE_W-1:0] left_q, right_q;
	logic [SUM_W-1:0]   sum_q;
	logic [AW-1:0]      red_q;
	logic [FRAC_W-1:0]  frac_q;
	logic               borrow_q;
	logic [AW-1:0]      tap1_q, tap2_q;
	logic               fwd1_q;
	logic signed [SAMPLE_W-1:0] ls1_q, rs1_q;
	logic signed [31:0] ldprod_q, rdprod_q;
	logic signed [31:0] linterp_q, rinterp_q;
	logic signed [47:0] lwprod_q, rwprod_q;

	logic               m_valid_q;
	logic [31:0]        m_data_q;

	// RAM ports.
	logic               lram_we, rram_we;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [SAMPLE_W-1:0] lram_wdata, rram_wdata;
	logic [SAMPLE_W-1:0] lram_rdata, rram_rdata;

	logic               in_xfer;
	logic               out_load;
	logic               clr_last;

	logic [RW-1:0]      red_c;
	logic [AW+1:0]      tap_v;
	logic [AW-1:0]      tap1_c;
	logic [AW-1:0]      write_next;

	logic signed [SAMPLE_W:0]   ldiff, rdiff;
	logic signed [33:0]         ldprod_c, rdprod_c;
	logic signed [48:0]         lwprod_c, rwprod_c;
	logic signed [SAMPLE_W-1:0] lout_c, rout_c;

	logic [POS_W:0]     sweep_add;

	// Saturate a rounded wet value plus the dry sample to 16 bits.
	function automatic logic signed [SAMPLE_W-1:0] mix_sat(
		input logic signed [SAMPLE_W-1:0] dry,
		input logic signed [48:0]         wprod
	);
		logic signed [48:0]       rnd;
		logic signed [17:0]       wet;
		logic signed [18:0]       total;
		rnd   = wprod + 49'sd1073741824;
		wet   = rnd[48:31];
		total = 19'(dry) + 19'(wet);
		if (total > 19'sd32767) begin
			mix_sat = 16'sh7FFF;
		end else if (total < -19'sd32768) begin
			mix_sat = 16'sh8000;
		end else begin
			mix_sat = total[SAMPLE_W-1:0];
		end
	endfunction

	sfl_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (DELAY_DEPTH)
	) u_left_ram (
		.clk   (clk),
		.we    (lram_we),
		.waddr (ram_waddr),
		.wdata (lram_wdata),
		.raddr (ram_raddr),
		.rdata (lram_rdata)
	);

	sfl_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (DELAY_DEPTH)
	) u_right_ram (
		.clk   (clk),
		.we    (rram_we),
		.waddr (ram_waddr),
		.wdata (rram_wdata),
		.raddr (ram_raddr),
		.rdata (rram_rdata)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);
	assign clr_last      = (clr_addr_q == LAST);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state and memory controls.
	always_comb begin
		state_d    = state_q;
		lram_we    = 1'b0;
		rram_we    = 1'b0;
		ram_waddr  = write_index_q;
		lram_wdata = left_q;
		rram_wdata = right_q;
		ram_raddr  = tap2_q;
		case (state_q)
			ST_CLEAR: begin
				lram_we    = 1'b1;
				rram_we    = 1'b1;
				ram_waddr  = clr_addr_q;
				lram_wdata = '0;
				rram_wdata = '0;
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = ST_MOD;
				end
			end
			ST_MOD:  state_d = ST_TAP;
			ST_TAP:  state_d = ST_RD1;
			ST_RD1: begin
				// The new pair goes in while the first tap is read; a tap that
				// lands on the slot being written is forwarded from the input.
				lram_we   = 1'b1;
				rram_we   = stereo_q;
				ram_raddr = tap1_q;
				state_d   = ST_RD2;
			end
			ST_RD2:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_INT;
			ST_INT:  state_d = ST_GAIN;
			ST_GAIN: state_d = ST_DONE;
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Integer delay modulo the depth.
	always_comb begin
		red_c = RW'(sum_q[SUM_W-1:FRAC_W]);
		for (int k = KS - 1; k >= 0; k--) begin
			if (red_c >= (DEP_R << k)) begin
				red_c = red_c - (DEP_R << k);
			end
		end
	end

	// First tap is one past the integer read position: write + 1 - borrow - delay,
	// brought back into the store range with one correction either way.
	always_comb begin
		tap_v = {2'b00, write_index_q} + (AW + 2)'(1) - (AW + 2)'(borrow_q)
			- {2'b00, red_q};
		if (tap_v[AW+1]) begin
			tap1_c = AW'(tap_v + DEP_T);
		end else if (tap_v >= DEP_T) begin
			tap1_c = AW'(tap_v - DEP_T);
		end else begin
			tap1_c = tap_v[AW-1:0];
		end
	end

	assign write_next = (write_index_q == LAST) ? '0 : write_index_q + AW'(1);

	// Interpolation as s1 * 65536 + (s2 - s1) * frac, which equals the weighted sum.
	assign ldiff    = (SAMPLE_W + 1)'($signed(lram_rdata)) - (SAMPLE_W + 1)'(ls1_q);
	assign rdiff    = (SAMPLE_W + 1)'($signed(rram_rdata)) - (SAMPLE_W + 1)'(rs1_q);
	assign ldprod_c = ldiff * $signed({1'b0, frac_q});
	assign rdprod_c = rdiff * $signed({1'b0, frac_q});
	assign lwprod_c = linterp_q * $signed({1'b0, mix_gain_q});
	assign rwprod_c = rinterp_q * $signed({1'b0, mix_gain_q});
	assign lout_c   = mix_sat(left_q, 49'(lwprod_q));
	assign rout_c   = stereo_q ? mix_sat(right_q, 49'(rwprod_q)) : right_q;

	assign sweep_add = {1'b0, sweep_pos_q} + (POS_W + 1)'(sweep_step_q);

	// Control state: configuration, write index, sweep, clearing pass, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_delay_q    <= BASE_W'(65536);
			sweep_step_q    <= '0;
			max_sweep_q     <= '0;
			mix_gain_q      <= GAIN_W'(32768);
			stereo_q        <= 1'b1;
			write_index_q   <= '0;
			sweep_pos_q     <= '0;
			sweep_falling_q <= 1'b0;
			clr_addr_q      <= '0;
			m_valid_q       <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_last ? '0 : clr_addr_q + AW'(1);
			end
			if (in_xfer) begin
				write_index_q <= write_next;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			// The sweep takes one triangle step when the result is handed over.
			if (out_load && (sweep_step_q != '0)) begin
				if (!sweep_falling_q) begin
					sweep_pos_q <= sweep_add[POS_W-1:0];
					if (sweep_add[POS_W-1:0] >= {1'b0, max_sweep_q}) begin
						sweep_falling_q <= 1'b1;
					end
				end else if (sweep_pos_q <= POS_W'(sweep_step_q)) begin
					sweep_pos_q     <= '0;
					sweep_falling_q <= 1'b0;
				end else begin
					sweep_pos_q <= sweep_pos_q - POS_W'(sweep_step_q);
				end
			end
			// Writing the sweep step or bound restarts the sweep at zero, rising.
			if (cfg_we) begin
				case (cfg_index)
					CFG_BASE_DELAY: base_delay_q <= cfg_wdata[BASE_W-1:0];
					CFG_SWEEP_STEP: begin
						sweep_step_q    <= cfg_wdata[STEP_W-1:0];
						sweep_pos_q     <= '0;
						sweep_falling_q <= 1'b0;
					end
					CFG_MAX_SWEEP: begin
						max_sweep_q     <= cfg_wdata[MAXSW_W-1:0];
						sweep_pos_q     <= '0;
						sweep_falling_q <= 1'b0;
					end
					CFG_MIX_GAIN:      mix_gain_q <= cfg_wdata[GAIN_W-1:0];
					CFG_STEREO_ENABLE: stereo_q   <= cfg_wdata[0];
					default: ;
				endcase
			end
		end
	end

	// Datapath registers, each loaded in its own step of the sequence.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			left_q  <= s_axis_tdata[15:0];
			right_q <= s_axis_tdata[31:16];
			sum_q   <= SUM_W'(base_delay_q) + SUM_W'(sweep_pos_q);
		end
		if (state_q == ST_MOD) begin
			red_q    <= red_c[AW-1:0];
			frac_q   <= FRAC_W'(0) - sum_q[FRAC_W-1:0];
			borrow_q <= (sum_q[FRAC_W-1:0] != '0);
		end
		if (state_q == ST_TAP) begin
			tap1_q <= tap1_c;
			tap2_q <= (tap1_c == LAST) ? '0 : tap1_c + AW'(1);
		end
		if (state_q == ST_RD1) begin
			fwd1_q <= (tap1_q == write_index_q);
		end
		if (state_q == ST_RD2) begin
			ls1_q <= fwd1_q ? left_q : $signed(lram_rdata);
			rs1_q <= (fwd1_q && stereo_q) ? right_q : $signed(rram_rdata);
		end
		if (state_q == ST_MUL) begin
			ldprod_q <= ldprod_c[31:0];
			rdprod_q <= rdprod_c[31:0];
		end
		if (state_q == ST_INT) begin
			linterp_q <= {ls1_q, 16'h0000} + ldprod_q;
			rinterp_q <= {rs1_q, 16'h0000} + rdprod_q;
		end
		if (state_q == ST_GAIN) begin
			lwprod_q <= lwprod_c[47:0];
			rwprod_q <= rwprod_c[47:0];
		end
		if (out_load) begin
			m_data_q <= {rout_c, lout_c};
		end
	end

endmodule
